// File: sv/psq_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the particle sprite quad expander
// no dependencies

package psq_pkg;

   localparam int QUO_W   = 32;
   localparam int NUMH_W  = 49;
   localparam int DENH_W  = 17;
   localparam int NUMF_W  = 31;
   localparam int DENF_W  = 16;
   localparam int DSHH_W  = DENH_W + QUO_W;
   localparam int DSHF_W  = DENF_W + QUO_W;

   localparam logic [1:0] CSR_NEW_PHASE = 2'd0;
   localparam logic [1:0] CSR_OLD_PHASE = 2'd1;
   localparam logic [1:0] CSR_DARKEN    = 2'd2;

   localparam logic [14:0] NEW_PHASE_RST = 15'd26214;
   localparam logic [15:0] OLD_PHASE_RST = 16'd6554;
   localparam logic [15:0] DARKEN_RST    = 16'd0;

   localparam logic [15:0] ONE_Q15  = 16'h8000;
   localparam logic [14:0] QUARTER  = 15'd16384;
   localparam logic [15:0] SIN_A    = 16'd51472;
   localparam logic [14:0] SIN_B    = 15'd21024;
   localparam logic [11:0] SIN_C    = 12'd2320;

   typedef struct packed {
      logic [14:0] tn;
      logic [15:0] to;
      logic [15:0] dk;
   } csr_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [16:0] sin_v;
      logic signed [16:0] cos_v;
      logic [15:0]        fa_add;
   } side_type;

   typedef struct packed {
      logic              valid;
      logic              neg_h;
      logic [NUMH_W-1:0] rem_h;
      logic [DENH_W-1:0] den_h;
      logic [QUO_W-1:0]  q_h;
      logic [NUMF_W-1:0] rem_f;
      logic [DENF_W-1:0] den_f;
      logic [QUO_W-1:0]  q_f;
      side_type          side;
   } div_stage_type;

endpackage

// File: sv/psq_front.sv
`timescale 1ns / 1ps
// front pipeline: input register, phase products, quarter-wave sine, divider operands
// depends on psq_pkg

module psq_front import psq_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           en,
   input  logic           req_valid,
   input  logic [183:0]   req_data,
   input  csr_type        csr,
   output div_stage_type  div_out
);

   // stage 1
   logic               v1_ff;
   logic signed [31:0] px1_ff, py1_ff, sz1_ff, sn1_ff;
   logic [15:0]        ang1_ff;
   logic signed [16:0] life1_ff;
   logic [15:0]        alpha1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid && !req_data[160] && (req_data[160:144] != 17'd0);
      end
      if (en) begin
         px1_ff    <= req_data[31:0];
         py1_ff    <= req_data[63:32];
         sz1_ff    <= req_data[95:64];
         sn1_ff    <= req_data[127:96];
         ang1_ff   <= req_data[143:128];
         life1_ff  <= req_data[160:144];
         alpha1_ff <= req_data[176:161];
      end
   end

   // stage 2
   logic [15:0]        t_c, a_c, dt_c, dd_c, mh_c, fm1_c, fm2_c;
   logic               is_new, is_old;
   logic signed [32:0] nms_c;
   logic signed [48:0] p1_in;
   logic signed [49:0] p2_in;
   logic [31:0]        pf_in;
   logic [14:0]        ra_in, rb_in;
   logic [29:0]        sqa_c, sqb_c;

   always_comb begin
      t_c    = (life1_ff > 17'sd32768) ? ONE_Q15 : life1_ff[15:0];
      a_c    = (alpha1_ff > ONE_Q15) ? ONE_Q15 : alpha1_ff;
      is_new = t_c > {1'b0, csr.tn};
      is_old = !is_new && (t_c < csr.to);
      dt_c   = t_c - {1'b0, csr.tn};
      dd_c   = ONE_Q15 - {1'b0, csr.tn};
      mh_c   = is_new ? dd_c : (is_old ? t_c : 16'd1);
      p1_in  = sz1_ff * $signed({1'b0, mh_c});
      nms_c  = {sn1_ff[31], sn1_ff} - {sz1_ff[31], sz1_ff};
      p2_in  = is_new ? nms_c * $signed({1'b0, dt_c}) : 50'sd0;
      fm1_c  = is_new ? (ONE_Q15 - a_c) : a_c;
      fm2_c  = is_new ? dt_c : (is_old ? t_c : 16'd1);
      pf_in  = fm1_c * fm2_c;
      ra_in  = {1'b0, ang1_ff[13:0]};
      rb_in  = QUARTER - ra_in;
      sqa_c  = ra_in * ra_in;
      sqb_c  = rb_in * rb_in;
   end

   logic               v2_ff;
   logic signed [31:0] px2_ff, py2_ff;
   logic signed [48:0] p1_ff;
   logic signed [49:0] p2_ff;
   logic [DENH_W-1:0]  denh2_ff;
   logic [NUMF_W-1:0]  pf2_ff;
   logic [DENF_W-1:0]  denf2_ff;
   logic [15:0]        fadd2_ff;
   logic [1:0]         quad2_ff;
   logic [14:0]        ra2_ff, rb2_ff, z2a2_ff, z2b2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
      if (en) begin
         px2_ff   <= px1_ff;
         py2_ff   <= py1_ff;
         p1_ff    <= p1_in;
         p2_ff    <= p2_in;
         denh2_ff <= is_new ? {dd_c, 1'b0} : (is_old ? {csr.to, 1'b0} : 17'd2);
         pf2_ff   <= pf_in[NUMF_W-1:0];
         denf2_ff <= is_new ? dd_c : (is_old ? csr.to : 16'd1);
         fadd2_ff <= is_new ? a_c : 16'd0;
         quad2_ff <= ang1_ff[15:14];
         ra2_ff   <= ra_in;
         rb2_ff   <= rb_in;
         z2a2_ff  <= sqa_c[28:14];
         z2b2_ff  <= sqb_c[28:14];
      end
   end

   // stage 3
   logic signed [49:0] num_c;
   logic [49:0]        mag_c;
   logic [26:0]        ca_c, cb_c;

   always_comb begin
      num_c = {p1_ff[48], p1_ff} + p2_ff;
      mag_c = num_c[49] ? ~num_c : num_c;
      ca_c  = SIN_C * z2a2_ff;
      cb_c  = SIN_C * z2b2_ff;
   end

   logic               v3_ff, neg3_ff;
   logic signed [31:0] px3_ff, py3_ff;
   logic [NUMH_W-1:0]  mag3_ff;
   logic [DENH_W-1:0]  denh3_ff;
   logic [NUMF_W-1:0]  pf3_ff;
   logic [DENF_W-1:0]  denf3_ff;
   logic [15:0]        fadd3_ff;
   logic [1:0]         quad3_ff;
   logic [14:0]        ra3_ff, rb3_ff, z2a3_ff, z2b3_ff, t1a3_ff, t1b3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
      if (en) begin
         neg3_ff  <= num_c[49];
         px3_ff   <= px2_ff;
         py3_ff   <= py2_ff;
         mag3_ff  <= mag_c[NUMH_W-1:0];
         denh3_ff <= denh2_ff;
         pf3_ff   <= pf2_ff;
         denf3_ff <= denf2_ff;
         fadd3_ff <= fadd2_ff;
         quad3_ff <= quad2_ff;
         ra3_ff   <= ra2_ff;
         rb3_ff   <= rb2_ff;
         z2a3_ff  <= z2a2_ff;
         z2b3_ff  <= z2b2_ff;
         t1a3_ff  <= SIN_B - {2'b0, ca_c[26:14]};
         t1b3_ff  <= SIN_B - {2'b0, cb_c[26:14]};
      end
   end

   // stage 4
   logic [29:0] da_c, db_c;

   always_comb begin
      da_c = z2a3_ff * t1a3_ff;
      db_c = z2b3_ff * t1b3_ff;
   end

   logic               v4_ff, neg4_ff;
   logic signed [31:0] px4_ff, py4_ff;
   logic [NUMH_W-1:0]  mag4_ff;
   logic [DENH_W-1:0]  denh4_ff;
   logic [NUMF_W-1:0]  pf4_ff;
   logic [DENF_W-1:0]  denf4_ff;
   logic [15:0]        fadd4_ff;
   logic [1:0]         quad4_ff;
   logic [14:0]        ra4_ff, rb4_ff;
   logic [15:0]        t2a4_ff, t2b4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= v3_ff;
      end
      if (en) begin
         neg4_ff  <= neg3_ff;
         px4_ff   <= px3_ff;
         py4_ff   <= py3_ff;
         mag4_ff  <= mag3_ff;
         denh4_ff <= denh3_ff;
         pf4_ff   <= pf3_ff;
         denf4_ff <= denf3_ff;
         fadd4_ff <= fadd3_ff;
         quad4_ff <= quad3_ff;
         ra4_ff   <= ra3_ff;
         rb4_ff   <= rb3_ff;
         t2a4_ff  <= SIN_A - da_c[29:14];
         t2b4_ff  <= SIN_A - db_c[29:14];
      end
   end

   // stage 5
   logic [30:0]        va_c, vb_c;
   logic [16:0]        sa_c, sb_c;
   logic signed [16:0] sin_in, cos_in;

   always_comb begin
      va_c = ra4_ff * t2a4_ff;
      vb_c = rb4_ff * t2b4_ff;
      sa_c = (va_c[30:14] > {1'b0, ONE_Q15}) ? {1'b0, ONE_Q15} : va_c[30:14];
      sb_c = (vb_c[30:14] > {1'b0, ONE_Q15}) ? {1'b0, ONE_Q15} : vb_c[30:14];
      case (quad4_ff)
         2'd0: begin
            sin_in = $signed(sa_c);
            cos_in = $signed(sb_c);
         end
         2'd1: begin
            sin_in = $signed(sb_c);
            cos_in = -$signed(sa_c);
         end
         2'd2: begin
            sin_in = -$signed(sa_c);
            cos_in = -$signed(sb_c);
         end
         default: begin
            sin_in = -$signed(sb_c);
            cos_in = $signed(sa_c);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_out.valid <= 1'b0;
      end else if (en) begin
         div_out.valid <= v4_ff;
      end
      if (en) begin
         div_out.neg_h       <= neg4_ff;
         div_out.rem_h       <= mag4_ff;
         div_out.den_h       <= denh4_ff;
         div_out.q_h         <= '0;
         div_out.rem_f       <= pf4_ff;
         div_out.den_f       <= denf4_ff;
         div_out.q_f         <= '0;
         div_out.side.pos_x  <= px4_ff;
         div_out.side.pos_y  <= py4_ff;
         div_out.side.sin_v  <= sin_in;
         div_out.side.cos_v  <= cos_in;
         div_out.side.fa_add <= fadd4_ff;
      end
   end

endmodule

// File: sv/psq_div.sv
`timescale 1ns / 1ps
// pipelined restoring divider, one quotient bit per stage, half-size and alpha lanes
// depends on psq_pkg

module psq_div import psq_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  div_stage_type din,
   output div_stage_type dout
);

   div_stage_type st [0:QUO_W];

   assign st[0] = din;
   assign dout  = st[QUO_W];

   genvar k;
   generate
      for (k = 0; k < QUO_W; k++) begin : g_stage
         localparam int B = QUO_W - 1 - k;
         logic [DSHH_W-1:0] dsh_h;
         logic [DSHF_W-1:0] dsh_f;
         div_stage_type     nx;

         always_comb begin
            dsh_h = {{QUO_W{1'b0}}, st[k].den_h} << B;
            dsh_f = {{QUO_W{1'b0}}, st[k].den_f} << B;
            nx    = st[k];
            if ({{(DSHH_W-NUMH_W){1'b0}}, st[k].rem_h} >= dsh_h) begin
               nx.rem_h = st[k].rem_h - dsh_h[NUMH_W-1:0];
               nx.q_h[B] = 1'b1;
            end
            if ({{(DSHF_W-NUMF_W){1'b0}}, st[k].rem_f} >= dsh_f) begin
               nx.rem_f = st[k].rem_f - dsh_f[NUMF_W-1:0];
               nx.q_f[B] = 1'b1;
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               st[k+1].valid <= 1'b0;
            end else if (en) begin
               st[k+1] <= nx;
            end
         end
      end
   endgenerate

endmodule

// File: sv/psq_back.sv
`timescale 1ns / 1ps
// back pipeline: rotation products, corner sums with saturation, corner sequencer
// depends on psq_pkg

module psq_back import psq_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  div_stage_type din,
   input  logic [15:0]   dk,
   output logic          en,
   input  logic          rsp_tready,
   output logic          rsp_tvalid,
   output logic [103:0]  rsp_tdata,
   output logic          rsp_tlast
);

   function automatic logic [31:0] sat32(input logic signed [36:0] v);
      if (v > 37'sd2147483647) begin
         return 32'h7fffffff;
      end else if (v < -37'sd2147483648) begin
         return 32'h80000000;
      end else begin
         return v[31:0];
      end
   endfunction

   // stage b1
   logic signed [32:0] half_c;
   logic [17:0]        fsum_c;
   logic [15:0]        fa_c, dkc_c;
   logic signed [17:0] cms_c, cps_c;

   always_comb begin
      half_c = din.neg_h ? ~$signed({1'b0, din.q_h}) : $signed({1'b0, din.q_h});
      fsum_c = {1'b0, din.q_f[16:0]} + {2'b0, din.side.fa_add};
      fa_c   = (fsum_c > {2'b0, ONE_Q15}) ? ONE_Q15 : fsum_c[15:0];
      dkc_c  = (dk > ONE_Q15) ? ONE_Q15 : dk;
      cms_c  = {din.side.cos_v[16], din.side.cos_v} - {din.side.sin_v[16], din.side.sin_v};
      cps_c  = {din.side.cos_v[16], din.side.cos_v} + {din.side.sin_v[16], din.side.sin_v};
   end

   logic               v1_ff;
   logic signed [31:0] px1_ff, py1_ff;
   logic [15:0]        fa1_ff;
   logic [31:0]        dap1_ff;
   logic signed [50:0] pp1_ff, qp1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= din.valid;
      end
      if (en) begin
         px1_ff  <= din.side.pos_x;
         py1_ff  <= din.side.pos_y;
         fa1_ff  <= fa_c;
         dap1_ff <= fa_c * dkc_c;
         pp1_ff  <= half_c * cms_c;
         qp1_ff  <= half_c * cps_c;
      end
   end

   // stage b2
   logic               v2_ff;
   logic signed [31:0] px2_ff, py2_ff;
   logic [15:0]        fa2_ff, da2_ff;
   logic signed [35:0] pp2_ff, qq2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
      if (en) begin
         px2_ff <= px1_ff;
         py2_ff <= py1_ff;
         fa2_ff <= fa1_ff;
         da2_ff <= dap1_ff[30:15];
         pp2_ff <= pp1_ff[50:15];
         qq2_ff <= qp1_ff[50:15];
      end
   end

   // stage b3: hold register for the four corners
   logic signed [36:0] pxe_c, pye_c, ppe_c, qqe_c;
   logic [31:0]        cx_in [0:3];
   logic [31:0]        cy_in [0:3];

   always_comb begin
      pxe_c    = {{5{px2_ff[31]}}, px2_ff};
      pye_c    = {{5{py2_ff[31]}}, py2_ff};
      ppe_c    = {pp2_ff[35], pp2_ff};
      qqe_c    = {qq2_ff[35], qq2_ff};
      cx_in[0] = sat32(pxe_c - qqe_c);
      cy_in[0] = sat32(pye_c - ppe_c);
      cx_in[1] = sat32(pxe_c - ppe_c);
      cy_in[1] = sat32(pye_c + qqe_c);
      cx_in[2] = sat32(pxe_c + qqe_c);
      cy_in[2] = sat32(pye_c + ppe_c);
      cx_in[3] = sat32(pxe_c + ppe_c);
      cy_in[3] = sat32(pye_c - qqe_c);
   end

   logic        hold_v_ff;
   logic [1:0]  k_ff;
   logic [31:0] cx_ff [0:3];
   logic [31:0] cy_ff [0:3];
   logic [15:0] fa3_ff, da3_ff;

   assign en = !hold_v_ff || (rsp_tready && (k_ff == 2'd3));

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_v_ff <= 1'b0;
         k_ff      <= 2'd0;
      end else begin
         if (en) begin
            hold_v_ff <= v2_ff;
         end
         if (hold_v_ff && rsp_tready) begin
            k_ff <= k_ff + 2'd1;
         end
      end
      if (en) begin
         cx_ff  <= cx_in;
         cy_ff  <= cy_in;
         fa3_ff <= fa2_ff;
         da3_ff <= da2_ff;
      end
   end

   assign rsp_tvalid = hold_v_ff;
   assign rsp_tlast  = (k_ff == 2'd3);
   assign rsp_tdata  = {4'd0, da3_ff, fa3_ff, k_ff[0] ^ k_ff[1], k_ff[1], k_ff,
                        cy_ff[k_ff], cx_ff[k_ff]};

endmodule

// File: sv/particle_sprite_quad_expand.sv
`timescale 1ns / 1ps
// particle sprite quad expander: one particle in, four rotated corners out
// an accepted transaction passes the front, divider and back registers before its first corner
// one corner per cycle while rsp_tready is high; input waits for a held quad's last corner
// dead particles are accepted at the input and give no corners
// synchronous active-high reset clears valid bits and the corner counter, loads csr defaults
// depends on psq_pkg, psq_front, psq_div, psq_back

module particle_sprite_quad_expand import psq_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // pos_x, pos_y, size, start_size, angle, life, alpha, zero fill
   input  logic [183:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // corner_x, corner_y, corner_index, tex_u, tex_v, faded_alpha, dark_alpha, zero fill
   output logic [103:0]  rsp_tdata,
   output logic          rsp_tlast,
   input  logic          csr_we,
   input  logic [1:0]    csr_index,
   input  logic [15:0]   csr_wdata
);

   csr_type       csr_ff;
   div_stage_type div_req, div_rsp;
   logic          en;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.tn <= NEW_PHASE_RST;
         csr_ff.to <= OLD_PHASE_RST;
         csr_ff.dk <= DARKEN_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_NEW_PHASE: csr_ff.tn <= csr_wdata[14:0];
            CSR_OLD_PHASE: csr_ff.to <= csr_wdata;
            CSR_DARKEN:    csr_ff.dk <= csr_wdata;
            default:       ;
         endcase
      end
   end

   assign req_tready = en;

   psq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .req_valid (req_tvalid),
      .req_data  (req_tdata),
      .csr       (csr_ff),
      .div_out   (div_req)
   );

   psq_div u_div (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .din   (div_req),
      .dout  (div_rsp)
   );

   psq_back u_back (
      .clock      (clock),
      .reset      (reset),
      .din        (div_rsp),
      .dk         (csr_ff.dk),
      .en         (en),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: tb/tb_particle_sprite_quad_expand.sv
`timescale 1ns / 1ps
// self-checking testbench for particle_sprite_quad_expand: directed, random particles,
// idling on both stream sides, config phases; corners checked by an in-bench predictor
// depends on psq_pkg and particle_sprite_quad_expand

module tb_particle_sprite_quad_expand;
   import psq_pkg::*;

   typedef struct {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] size;
      logic signed [31:0] start_size;
      logic [15:0]        angle;
      logic signed [16:0] life;
      logic [15:0]        alpha;
   } particle_type;

   typedef struct {
      logic [31:0] cx;
      logic [31:0] cy;
      logic [1:0]  idx;
      logic        tu;
      logic        tv;
      logic [15:0] fa;
      logic [15:0] da;
      logic        qend;
   } corner_type;

   logic          clock = 0;
   logic          reset = 1;
   logic          req_tvalid = 0;
   logic          req_tready;
   logic [183:0]  req_tdata = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 0;
   logic [103:0]  rsp_tdata;
   logic          rsp_tlast;
   logic          csr_we = 0;
   logic [1:0]    csr_index = CSR_NEW_PHASE;
   logic [15:0]   csr_wdata = '0;

   particle_type particle_q[$];
   corner_type   corner_q[$];
   int        err_count = 0;
   int        accepted = 0;
   int        pushed = 0;
   bit        calm = 0;
   bit        req_tready_seen = 0;
   int        gap_in = 0;
   int        gap_out = 0;
   longint    cur_tn, cur_to, cur_dk;

   particle_sprite_quad_expand u_top (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   function automatic longint fdiv(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q -= 1;
      return q;
   endfunction

   function automatic longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint qsin(longint r);
      longint z2, t1, t2, v;
      z2 = (r * r) >>> 14;
      t1 = 21024 - ((2320 * z2) >>> 14);
      t2 = 51472 - ((z2 * t1) >>> 14);
      v = (r * t2) >>> 14;
      if (v > 32768) v = 32768;
      return v;
   endfunction

   task automatic predict_corners(particle_type p);
      longint t, a, dk, half, fa, da, sv, cv, r1, r2, pp, qq, d, sz, sn, px, py;
      longint cx[4], cy[4];
      corner_type c;
      if (p.life <= 0) return;
      t = p.life > 32768 ? 32768 : longint'(p.life);
      a = p.alpha > 32768 ? 32768 : longint'(p.alpha);
      dk = cur_dk > 32768 ? 32768 : cur_dk;
      sz = p.size; sn = p.start_size; px = p.pos_x; py = p.pos_y;
      if (t > cur_tn) begin
         d = 32768 - cur_tn;
         half = fdiv(sz * d + (sn - sz) * (t - cur_tn), 2 * d);
         fa = a + ((32768 - a) * (t - cur_tn)) / d;
      end else if (t < cur_to) begin
         half = fdiv(sz * t, 2 * cur_to);
         fa = (a * t) / cur_to;
      end else begin
         half = fdiv(sz, 2);
         fa = a;
      end
      if (fa > 32768) fa = 32768;
      if (fa < 0) fa = 0;
      da = (fa * dk) >>> 15;
      r1 = qsin(p.angle[13:0]);
      r2 = qsin(16384 - p.angle[13:0]);
      case (p.angle[15:14])
         2'd0: begin sv = r1; cv = r2; end
         2'd1: begin sv = r2; cv = -r1; end
         2'd2: begin sv = -r1; cv = -r2; end
         default: begin sv = -r2; cv = r1; end
      endcase
      pp = fdiv(half * (cv - sv), 32768);
      qq = fdiv(half * (cv + sv), 32768);
      cx[0] = px - qq; cy[0] = py - pp;
      cx[1] = px - pp; cy[1] = py + qq;
      cx[2] = px + qq; cy[2] = py + pp;
      cx[3] = px + pp; cy[3] = py - qq;
      for (int k = 0; k < 4; k++) begin
         c.cx = 32'(sat32(cx[k]));
         c.cy = 32'(sat32(cy[k]));
         c.idx = 2'(k);
         c.tu = (k >= 2);
         c.tv = (k == 1 || k == 2);
         c.fa = fa[15:0];
         c.da = da[15:0];
         c.qend = (k == 3);
         corner_q.push_back(c);
      end
   endtask

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      err_count++;
   endtask

   // input acceptance
   always @(posedge clock) begin
      req_tready_seen <= !reset && req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready) begin
         predict_corners(particle_q.pop_front());
         accepted++;
      end
   end

   // driver
   always @(negedge clock) begin
      particle_type p;
      if (!reset) begin
         if (!req_tvalid || req_tready_seen) begin
            if (gap_in > 0) begin
               gap_in--;
               req_tvalid <= 0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
               gap_in = $urandom_range(1, 12) - 1;
               req_tvalid <= 0;
            end else if (particle_q.size() > 0) begin
               p = particle_q[0];
               req_tdata <= {7'd0, p.alpha, p.life, p.angle, p.start_size, p.size,
                             p.pos_y, p.pos_x};
               req_tvalid <= 1;
            end else begin
               req_tvalid <= 0;
            end
         end
         if (gap_out > 0) begin
            gap_out--;
            rsp_tready <= 0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            gap_out = $urandom_range(1, 12) - 1;
            rsp_tready <= 0;
         end else begin
            rsp_tready <= 1;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      corner_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (corner_q.size() == 0) begin
            report("unexpected corner", rsp_tdata[31:0], 32'd0);
         end else begin
            e = corner_q.pop_front();
            if (rsp_tdata[31:0] !== e.cx) report("corner_x", rsp_tdata[31:0], e.cx);
            if (rsp_tdata[63:32] !== e.cy) report("corner_y", rsp_tdata[63:32], e.cy);
            if (rsp_tdata[65:64] !== e.idx)
               report("corner_index", 32'(rsp_tdata[65:64]), 32'(e.idx));
            if (rsp_tdata[66] !== e.tu) report("tex_u", 32'(rsp_tdata[66]), 32'(e.tu));
            if (rsp_tdata[67] !== e.tv) report("tex_v", 32'(rsp_tdata[67]), 32'(e.tv));
            if (rsp_tdata[83:68] !== e.fa)
               report("faded_alpha", 32'(rsp_tdata[83:68]), 32'(e.fa));
            if (rsp_tdata[99:84] !== e.da)
               report("dark_alpha", 32'(rsp_tdata[99:84]), 32'(e.da));
            if (rsp_tdata[103:100] !== 4'd0) report("fill", 32'(rsp_tdata[103:100]), 32'd0);
            if (rsp_tlast !== e.qend) report("quad_end", 32'(rsp_tlast), 32'(e.qend));
         end
      end
   end

   task automatic csr_write(logic [1:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 0;
      case (idx)
         CSR_NEW_PHASE: cur_tn = val[14:0];
         CSR_OLD_PHASE: cur_to = val;
         default: cur_dk = val;
      endcase
   endtask

   function automatic logic signed [31:0] rnd_len();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return 32'sh7fffffff;
         2: return 32'sh80000000;
         default: return $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
      endcase
   endfunction

   function automatic particle_type rnd_particle();
      particle_type p;
      p.pos_x = $urandom_range(0, 3) == 0 ? $urandom : rnd_len();
      p.pos_y = $urandom_range(0, 3) == 0 ? $urandom : rnd_len();
      p.size = rnd_len();
      p.start_size = rnd_len();
      p.angle = 16'($urandom);
      case ($urandom_range(0, 7))
         0: p.life = 17'($urandom);
         1: p.life = -$signed({1'b0, 16'($urandom)});
         2: p.life = 17'sd32768;
         default: p.life = 17'($urandom_range(1, 32768));
      endcase
      p.alpha = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 32768));
      return p;
   endfunction

   task automatic add(logic signed [31:0] x, logic signed [31:0] y, logic signed [31:0] s,
                      logic signed [31:0] n, logic [15:0] ang, logic signed [16:0] l,
                      logic [15:0] a);
      particle_type p;
      p.pos_x = x; p.pos_y = y; p.size = s; p.start_size = n;
      p.angle = ang; p.life = l; p.alpha = a;
      particle_q.push_back(p);
      pushed++;
   endtask

   task automatic drain();
      while (accepted < pushed || corner_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   initial begin
      cur_tn = NEW_PHASE_RST;
      cur_to = OLD_PHASE_RST;
      cur_dk = DARKEN_RST;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 0;
      // directed: extremes, phases, dead, over-range, quadrant angles
      add(0, 0, 32'sh00100000, 32'sh00200000, 16'd0, 17'sd32768, 16'd32768);
      add(0, 0, 32'sh00100000, 32'sh00200000, 16'd16384, 17'sd30000, 16'd1000);
      add(0, 0, 32'sh00100000, 32'sh00200000, 16'd32768, 17'sd10000, 16'd20000);
      add(0, 0, 32'sh00100000, 32'sh00200000, 16'd49152, 17'sd100, 16'd20000);
      add(1, 2, 32'sh00100000, 0, 16'hffff, 17'sd1, 16'hffff);
      add(5, 5, 32'sh7fffffff, 32'sh80000000, 16'd8192, 17'sd0, 16'd100);
      add(5, 5, 32'sh7fffffff, 32'sh80000000, 16'd8192, -17'sd65536, 16'd100);
      add(5, 5, 32'sh10000, 32'sh10000, 16'd8192, 17'sh0ffff, 16'd100);
      add(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 16'd8192,
          17'sd32768, 16'd0);
      add(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 16'd40000,
          17'sd3000, 16'd32768);
      add(32'shffffffff, 32'shffffffff, -32'sd1, -32'sd1, 16'd1, 17'sd26214, 16'd5);
      add(0, 0, 32'sh80000000, 32'sh7fffffff, 16'd24576, 17'sd6554, 16'd7);
      drain();
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin
               csr_write(CSR_NEW_PHASE, 16'd0);
               csr_write(CSR_OLD_PHASE, 16'd1);
               csr_write(CSR_DARKEN, 16'd32768);
            end
            1: begin
               csr_write(CSR_NEW_PHASE, 16'd32767);
               csr_write(CSR_OLD_PHASE, 16'd32768);
               csr_write(CSR_DARKEN, 16'hffff);
            end
            2: begin
               csr_write(CSR_NEW_PHASE, 16'd100);
               csr_write(CSR_OLD_PHASE, 16'd20000);
               csr_write(CSR_DARKEN, 16'd12345);
            end
            3: begin
               csr_write(CSR_NEW_PHASE, 16'hffff);
               csr_write(CSR_OLD_PHASE, 16'd0);
               csr_write(CSR_DARKEN, 16'd1);
            end
            default: begin
               csr_write(CSR_NEW_PHASE, 16'($urandom_range(0, 32767)));
               csr_write(CSR_OLD_PHASE, 16'($urandom_range(1, 32768)));
               csr_write(CSR_DARKEN, 16'($urandom));
            end
         endcase
         if (ph == 5) calm = 1;
         for (int i = 0; i < 52; i++) begin
            particle_q.push_back(rnd_particle());
            pushed++;
         end
         drain();
      end
      if (err_count == 0)
         $display("tb_particle_sprite_quad_expand: PASS");
      else
         $display("tb_particle_sprite_quad_expand: FAIL");
      $finish;
   end

   initial begin
      #2000000;
      $display("tb_particle_sprite_quad_expand: FAIL");
      $finish;
   end

endmodule

// File: sim.f
sv/psq_pkg.sv
sv/psq_front.sv
sv/psq_div.sv
sv/psq_back.sv
sv/particle_sprite_quad_expand.sv
tb/tb_particle_sprite_quad_expand.sv
